FILE: hdl/phc_pkg.sv
// Shared constants for the point-to-hex-cell pipeline.
// No dependencies; imported by every module of the block.
`default_nettype none

package phc_pkg;

    localparam int COORD_WIDTH_DEF = 16;
    localparam int FRAC_BITS_DEF   = 8;
    localparam int GUARD_BITS      = 8;
    localparam int CONST_FRAC      = 16;
    localparam int CONST_WIDTH     = 18;
    localparam int OUT_WIDTH       = 10;

    localparam logic signed [CONST_WIDTH-1:0] K_SIN60    = 18'sd56756;
    localparam logic signed [CONST_WIDTH-1:0] K_INV_UNIT = 18'sd75674;

endpackage

`default_nettype wire

FILE: hdl/phc_rotate.sv
// First stage: widen the point and rotate it by 30 degrees.
// Depends on phc_pkg.
`default_nettype none

module phc_rotate #(
    parameter int COORD_WIDTH = 16,
    parameter int XW          = COORD_WIDTH + 10
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          up_valid,
    output logic                               up_ready,
    input  wire logic signed [COORD_WIDTH-1:0] point_x,
    input  wire logic signed [COORD_WIDTH-1:0] point_y,
    output logic                               dn_valid,
    input  wire logic                          dn_ready,
    output logic signed [XW-1:0]               rot_x,
    output logic signed [XW-1:0]               rot_y
);
    import phc_pkg::*;

    localparam int PW = COORD_WIDTH + GUARD_BITS;
    localparam int MW = PW + CONST_WIDTH;

    logic signed [PW-1:0] px_w;
    logic signed [PW-1:0] py_w;
    logic signed [MW-1:0] bias;
    logic signed [MW-1:0] px_s_prod;
    logic signed [MW-1:0] py_s_prod;
    logic signed [MW-1:0] px_s_sum;
    logic signed [MW-1:0] py_s_sum;
    logic signed [PW:0]   px_inc;
    logic signed [PW:0]   py_inc;
    logic signed [PW-1:0] px_h;
    logic signed [PW-1:0] py_h;
    logic signed [XW-1:0] x_next;
    logic signed [XW-1:0] y_next;
    logic signed [XW-1:0] x_reg;
    logic signed [XW-1:0] y_reg;
    logic                 valid_reg;

    assign px_w = $signed({point_x, {GUARD_BITS{1'b0}}});
    assign py_w = $signed({point_y, {GUARD_BITS{1'b0}}});
    assign bias = $signed(MW'(1) << (CONST_FRAC - 1));

    assign px_s_prod = px_w * K_SIN60;
    assign py_s_prod = py_w * K_SIN60;
    assign px_s_sum  = px_s_prod + bias;
    assign py_s_sum  = py_s_prod + bias;

    assign px_inc = (PW+1)'(px_w) + (PW+1)'(1);
    assign py_inc = (PW+1)'(py_w) + (PW+1)'(1);
    assign px_h   = px_inc[PW:1];
    assign py_h   = py_inc[PW:1];

    assign x_next = XW'(px_s_sum[MW-1:CONST_FRAC]) + XW'(py_h);
    assign y_next = XW'(py_s_sum[MW-1:CONST_FRAC]) - XW'(px_h);

    assign up_ready = !valid_reg || dn_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (up_ready) begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (up_valid && up_ready) begin
            x_reg <= x_next;
            y_reg <= y_next;
        end
    end

    assign dn_valid = valid_reg;
    assign rot_x    = x_reg;
    assign rot_y    = y_reg;

endmodule

`default_nettype wire

FILE: hdl/phc_project.sv
// Two stages: project onto the three cube axes, then scale by the inverse cell unit.
// Depends on phc_pkg.
`default_nettype none

module phc_project #(
    parameter int XW = 26,
    parameter int DW = XW + 4
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 up_valid,
    output logic                      up_ready,
    input  wire logic signed [XW-1:0] rot_x,
    input  wire logic signed [XW-1:0] rot_y,
    output logic                      dn_valid,
    input  wire logic                 dn_ready,
    output logic signed [DW-1:0]      proj_d [3]
);
    import phc_pkg::*;

    localparam int TW  = XW + 2;
    localparam int MWA = XW + CONST_WIDTH;
    localparam int MWB = TW + CONST_WIDTH;

    // projection stage
    logic signed [MWA-1:0] bias_a;
    logic signed [XW:0]    x_inc;
    logic signed [XW-1:0]  xh;
    logic signed [MWA-1:0] ys_prod;
    logic signed [MWA-1:0] ys_sum;
    logic signed [TW-1:0]  ys;
    logic signed [TW-1:0]  ty_next;
    logic signed [TW-1:0]  tz_next;
    logic signed [XW-1:0]  xa_reg;
    logic signed [TW-1:0]  ty_reg;
    logic signed [TW-1:0]  tz_reg;
    logic                  va_reg;
    logic                  ready_a;

    // scaling stage
    logic signed [MWB-1:0] bias_b;
    logic signed [MWB-1:0] prod_b [3];
    logic signed [MWB-1:0] sum_b  [3];
    logic signed [DW-1:0]  d_next [3];
    logic signed [DW-1:0]  d_reg  [3];
    logic                  vb_reg;
    logic                  ready_b;

    assign bias_a  = $signed(MWA'(1) << (CONST_FRAC - 1));
    assign x_inc   = (XW+1)'(rot_x) + (XW+1)'(1);
    assign xh      = x_inc[XW:1];
    assign ys_prod = rot_y * K_SIN60;
    assign ys_sum  = ys_prod + bias_a;
    assign ys      = ys_sum[MWA-1:CONST_FRAC];
    assign ty_next = ys - TW'(xh);
    assign tz_next = -TW'(xh) - ys;

    assign ready_a  = !va_reg || ready_b;
    assign up_ready = ready_a;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            va_reg <= 1'b0;
        end else if (ready_a) begin
            va_reg <= up_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (up_valid && ready_a) begin
            xa_reg <= rot_x;
            ty_reg <= ty_next;
            tz_reg <= tz_next;
        end
    end

    assign bias_b    = $signed(MWB'(1) << (CONST_FRAC - 1));
    assign prod_b[0] = TW'(xa_reg) * K_INV_UNIT;
    assign prod_b[1] = ty_reg * K_INV_UNIT;
    assign prod_b[2] = tz_reg * K_INV_UNIT;

    for (genvar g = 0; g < 3; g++) begin : g_scale
        assign sum_b[g]  = prod_b[g] + bias_b;
        assign d_next[g] = sum_b[g][MWB-1:CONST_FRAC];
    end

    assign ready_b = !vb_reg || dn_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vb_reg <= 1'b0;
        end else if (ready_b) begin
            vb_reg <= va_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (va_reg && ready_b) begin
            d_reg <= d_next;
        end
    end

    assign dn_valid = vb_reg;
    assign proj_d   = d_reg;

endmodule

`default_nettype wire

FILE: hdl/phc_round.sv
// Round each projection to the nearest cell index and form its rounding error.
// Depends on phc_pkg.
`default_nettype none

module phc_round #(
    parameter int DW = 30,
    parameter int WB = 16
) (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  wire logic                                  up_valid,
    output logic                                       up_ready,
    input  wire logic signed [DW-1:0]                  proj_d [3],
    output logic                                       dn_valid,
    input  wire logic                                  dn_ready,
    output logic signed [phc_pkg::OUT_WIDTH-1:0]       cell_r [3],
    output logic [WB-1:0]                              cell_e [3]
);
    import phc_pkg::*;

    localparam int RW = ((DW > WB + OUT_WIDTH) ? DW : (WB + OUT_WIDTH)) + 1;

    logic signed [RW-1:0]        half_r;
    logic [WB-1:0]               half_w;
    logic signed [RW-1:0]        dd     [3];
    logic signed [WB:0]          diff   [3];
    logic [WB:0]                 mag    [3];
    logic signed [OUT_WIDTH-1:0] r_next [3];
    logic [WB-1:0]               e_next [3];
    logic signed [OUT_WIDTH-1:0] r_reg  [3];
    logic [WB-1:0]               e_reg  [3];
    logic                        valid_reg;

    assign half_r = $signed(RW'(1) << (WB - 1));
    assign half_w = WB'(1) << (WB - 1);

    for (genvar g = 0; g < 3; g++) begin : g_lane
        assign dd[g]     = RW'(proj_d[g]) + half_r;
        assign diff[g]   = $signed({1'b0, half_w}) - $signed({1'b0, dd[g][WB-1:0]});
        assign mag[g]    = diff[g][WB] ? -diff[g] : diff[g];
        assign e_next[g] = mag[g][WB-1:0];
        assign r_next[g] = dd[g][WB+OUT_WIDTH-1:WB];
    end

    assign up_ready = !valid_reg || dn_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (up_ready) begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (up_valid && up_ready) begin
            r_reg <= r_next;
            e_reg <= e_next;
        end
    end

    assign dn_valid = valid_reg;
    assign cell_r   = r_reg;
    assign cell_e   = e_reg;

endmodule

`default_nettype wire

FILE: hdl/phc_resolve.sv
// Last stage: force the cube sum to zero on the coordinate with the largest error.
// Depends on phc_pkg; drives the result register.
`default_nettype none

module phc_resolve #(
    parameter int WB = 16
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            up_valid,
    output logic                                 up_ready,
    input  wire logic signed [phc_pkg::OUT_WIDTH-1:0] cell_r [3],
    input  wire logic [WB-1:0]                   cell_e [3],
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output logic signed [phc_pkg::OUT_WIDTH-1:0] m_cube_i,
    output logic signed [phc_pkg::OUT_WIDTH-1:0] m_cube_j,
    output logic signed [phc_pkg::OUT_WIDTH-1:0] m_cube_k
);
    import phc_pkg::*;

    logic signed [OUT_WIDTH-1:0] sum;
    logic signed [OUT_WIDTH-1:0] i_next;
    logic signed [OUT_WIDTH-1:0] j_next;
    logic signed [OUT_WIDTH-1:0] k_next;
    logic signed [OUT_WIDTH-1:0] i_reg;
    logic signed [OUT_WIDTH-1:0] j_reg;
    logic signed [OUT_WIDTH-1:0] k_reg;
    logic                        valid_reg;

    assign sum = cell_r[0] + cell_r[1] + cell_r[2];

    always_comb begin
        i_next = cell_r[0];
        j_next = cell_r[1];
        k_next = cell_r[2];
        priority if (cell_e[0] >= cell_e[1] && cell_e[0] >= cell_e[2]) begin
            i_next = cell_r[0] - sum;
        end else if (cell_e[1] >= cell_e[0] && cell_e[1] >= cell_e[2]) begin
            j_next = cell_r[1] - sum;
        end else begin
            k_next = cell_r[2] - sum;
        end
    end

    assign up_ready = !valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (up_ready) begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (up_valid && up_ready) begin
            i_reg <= i_next;
            j_reg <= j_next;
            k_reg <= k_next;
        end
    end

    assign m_valid  = valid_reg;
    assign m_cube_i = i_reg;
    assign m_cube_j = j_reg;
    assign m_cube_k = k_reg;

endmodule

`default_nettype wire

FILE: hdl/point_to_hex_cell_core.sv
// Point to hexagonal cube coordinate mapper: rotate, project, scale, round, resolve.
// Five register stages lie between input transfer and result valid; each holds under stall.
// Throughput: one point per cycle while m_ready is high; each stage has its own valid bit.
// Reset: synchronous, active low, empties every stage; data registers are not reset.
// Depends on phc_pkg, phc_rotate, phc_project, phc_round and phc_resolve.
`default_nettype none

module point_to_hex_cell_core #(
    parameter int COORD_WIDTH = phc_pkg::COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = phc_pkg::FRAC_BITS_DEF
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire logic signed [COORD_WIDTH-1:0]       s_point_x,
    input  wire logic signed [COORD_WIDTH-1:0]       s_point_y,
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output logic signed [phc_pkg::OUT_WIDTH-1:0]     m_cube_i,
    output logic signed [phc_pkg::OUT_WIDTH-1:0]     m_cube_j,
    output logic signed [phc_pkg::OUT_WIDTH-1:0]     m_cube_k
);
    import phc_pkg::*;

    localparam int XW = COORD_WIDTH + GUARD_BITS + 2;
    localparam int DW = XW + 4;
    localparam int WB = FRAC_BITS + GUARD_BITS;

    logic                        rot_valid;
    logic                        rot_ready;
    logic signed [XW-1:0]        rot_x;
    logic signed [XW-1:0]        rot_y;
    logic                        proj_valid;
    logic                        proj_ready;
    logic signed [DW-1:0]        proj_d [3];
    logic                        rnd_valid;
    logic                        rnd_ready;
    logic signed [OUT_WIDTH-1:0] cell_r [3];
    logic [WB-1:0]               cell_e [3];

    phc_rotate #(
        .COORD_WIDTH (COORD_WIDTH),
        .XW          (XW)
    ) u_rotate (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .up_valid (s_valid),
        .up_ready (s_ready),
        .point_x  (s_point_x),
        .point_y  (s_point_y),
        .dn_valid (rot_valid),
        .dn_ready (rot_ready),
        .rot_x    (rot_x),
        .rot_y    (rot_y)
    );

    phc_project #(
        .XW (XW),
        .DW (DW)
    ) u_project (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .up_valid (rot_valid),
        .up_ready (rot_ready),
        .rot_x    (rot_x),
        .rot_y    (rot_y),
        .dn_valid (proj_valid),
        .dn_ready (proj_ready),
        .proj_d   (proj_d)
    );

    phc_round #(
        .DW (DW),
        .WB (WB)
    ) u_round (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .up_valid (proj_valid),
        .up_ready (proj_ready),
        .proj_d   (proj_d),
        .dn_valid (rnd_valid),
        .dn_ready (rnd_ready),
        .cell_r   (cell_r),
        .cell_e   (cell_e)
    );

    phc_resolve #(
        .WB (WB)
    ) u_resolve (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .up_valid (rnd_valid),
        .up_ready (rnd_ready),
        .cell_r   (cell_r),
        .cell_e   (cell_e),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_cube_i (m_cube_i),
        .m_cube_j (m_cube_j),
        .m_cube_k (m_cube_k)
    );

    a_cube_sum_zero : assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (OUT_WIDTH'(m_cube_i + m_cube_j + m_cube_k) == OUT_WIDTH'(0)))
        else $error("cube coordinates do not sum to zero");

    a_drain_opens_input : assert property (@(posedge aclk) disable iff (!aresetn)
        m_ready |-> s_ready)
        else $error("input blocked while result side drains");

    a_reset_empties : assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid straight after reset");

    a_rnd_ready_follows : assert property (@(posedge aclk) disable iff (!aresetn)
        !rnd_valid |-> proj_ready)
        else $error("empty round stage stalls upstream");

endmodule

`default_nettype wire
